### rtl/tfg_pkg.sv
// Shared types, constants and elaboration-time table functions for the twiddle generator.
package tfg_pkg;

    localparam int          ANGLE_FRACTION_BITS  = 24;
    localparam int          CORDIC_STEPS         = 24;
    localparam int          OUTPUT_FRACTION_BITS = 16;
    localparam int          QUOT_BITS            = 22;
    localparam logic [16:0] MAX_POINTS           = 17'd65536;
    localparam logic [63:0] ONE_Q62              = 64'd1 << 62;
    localparam logic        REG_IDX_TRANSFORM_SIZE = 1'b0;

    // Fold and range information that travels with an item.
    typedef struct packed {
        logic       oor;
        logic [2:0] fold;
    } tfg_side_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        tfg_side_t   side;
        logic [15:0] pos;
        logic [16:0] size;
    } tfg_item_t;

    // Restoring division used only to build constants during elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arctangent of 1/d in Q62 by its alternating series.
    function automatic logic [63:0] atan_recip(input logic [63:0] d);
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] j;
        pw  = udiv64(ONE_Q62, d);
        acc = '0;
        j   = '0;
        while (pw != 64'd0)
        begin
            term = udiv64(pw, 64'd2 * j + 64'd1);
            if (j[0] == 1'b0)
                acc = acc + term;
            else
                acc = acc - term;
            pw = udiv64(udiv64(pw, d), d);
            j  = j + 64'd1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Pi in Q62, which is also two pi in Q61.
    function automatic logic [63:0] calc_pi_q62();
        return 64'd16 * atan_recip(64'd5) - 64'd4 * atan_recip(64'd239);
    endfunction

    function automatic logic [63:0] calc_gain_start();
        logic [63:0] k2;
        k2 = ONE_Q62;
        for (int i = 0; i < CORDIC_STEPS; i++)
            k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
        return isqrt64(k2) << 31;
    endfunction

    localparam logic [63:0] PI_Q62     = calc_pi_q62();
    localparam logic [63:0] GAIN_START = calc_gain_start();

    function automatic logic [63:0] atan_entry(input int i);
        if (i == 0)
            return PI_Q62 >> 2;
        return atan_recip(64'd1 << i);
    endfunction

endpackage

### rtl/twiddle_factor_generator_unit.sv
// Throughput: one item per cycle while the output is not stalled; the divider,
// multiplier and CORDIC are fully pipelined.
// A four-entry queue lets the front end keep accepting while the back end stalls.
// Reset (rst_n, asynchronous, active low) empties all stages and sets transform_size to 1.
// Top level of the twiddle factor generator with its configuration register.
module twiddle_factor_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] twiddle_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [17:0] cos_value, [35:18] sin_value, [39:36] zero
    output logic        m_tuser    // [0] index_out_of_range
);

    logic [16:0]        transform_size_reg;
    logic               f_valid, q_full, q_empty, q_pop;
    tfg_pkg::tfg_item_t f_item, q_item;

    assign pready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            transform_size_reg <= 17'd1;
        else if (psel && penable && pwrite && paddr[2] == tfg_pkg::REG_IDX_TRANSFORM_SIZE)
            transform_size_reg <= pwdata[16:0];
    end

    assign prdata = (paddr[2] == tfg_pkg::REG_IDX_TRANSFORM_SIZE) ?
                    {15'd0, transform_size_reg} : 32'd0;

    tfg_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .transform_size (transform_size_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_index       (s_tdata),
        .out_valid      (f_valid),
        .out_ready      (!q_full),
        .out_item       (f_item)
    );

    tfg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && !q_full),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    tfg_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/tfg_front.sv
// Front end: accepts indices, checks range and folds the angle into the first octant.
module tfg_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [16:0]          transform_size,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          in_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tfg_pkg::tfg_item_t   out_item
);

    logic               valid_reg;
    tfg_pkg::tfg_item_t item_reg;
    tfg_pkg::tfg_item_t item_next;
    logic [16:0]        n_eff;
    logic [18:0]        full, p0, p1, p2, p3, n19;
    logic               f4, f2, f1;
    logic               load;

    // Clamp the size, then apply the three reflections.
    always_comb
    begin
        n_eff = (transform_size > tfg_pkg::MAX_POINTS) ? tfg_pkg::MAX_POINTS : transform_size;
        n19   = {2'b00, n_eff};
        full  = {n_eff, 2'b00};
        p0    = {1'b0, in_index, 2'b00};
        f4    = p0 > (full - p0);
        p1    = f4 ? (full - p0) : p0;
        f2    = p1 > n19;
        p2    = f2 ? (p1 - n19) : p1;
        f1    = p2 > (n19 - p2);
        p3    = f1 ? (n19 - p2) : p2;
        item_next.side.oor  = {1'b0, in_index} >= n_eff;
        item_next.side.fold = {f4, f2, f1};
        item_next.pos       = p3[15:0];
        item_next.size      = n_eff;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

endmodule

### rtl/tfg_queue.sv
// Four-entry queue between the front end and the back end.
module tfg_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tfg_pkg::tfg_item_t   push_item,
    output logic                 full,
    input  logic                 pop,
    output tfg_pkg::tfg_item_t   pop_item,
    output logic                 empty
);

    tfg_pkg::tfg_item_t mem_reg [4];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         count_reg;

    assign full     = count_reg == 3'd4;
    assign empty    = count_reg == 3'd0;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (push && !pop)
                count_reg <= count_reg + 3'd1;
            else if (pop && !push)
                count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### rtl/tfg_back.sv
// Back end: pipelined divider, angle multiply, CORDIC rotation and output folding.
module tfg_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  tfg_pkg::tfg_item_t   q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int QB = tfg_pkg::QUOT_BITS;
    localparam int CS = tfg_pkg::CORDIC_STEPS;
    localparam logic [85:0] ROUND_ANGLE = 86'd1 << (tfg_pkg::ANGLE_FRACTION_BITS - 2);

    logic en;

    // Divider pipeline: index 0 is the load stage.
    logic [18:0]         dv_rem_reg  [QB+1];
    logic [QB-1:0]       dv_low_reg  [QB+1];
    logic [QB-1:0]       dv_q_reg    [QB+1];
    logic [18:0]         dv_den_reg  [QB+1];
    tfg_pkg::tfg_side_t  dv_side_reg [QB+1];
    logic [QB:0]         dv_valid_reg;
    logic [40:0]         ld_num;

    // Multiply stage.
    logic [53:0]         mp_lo_reg, mp_hi_reg;
    tfg_pkg::tfg_side_t  mp_side_reg;
    logic                mp_valid_reg;
    logic [85:0]         ang_prod;

    // CORDIC stages.
    logic signed [63:0]  cx_reg [CS+1];
    logic signed [63:0]  cy_reg [CS+1];
    logic signed [63:0]  cz_reg [CS+1];
    tfg_pkg::tfg_side_t  c_side_reg [CS+1];
    logic [CS:0]         c_valid_reg;

    // Output register.
    logic                out_valid_reg;
    logic [17:0]         cos_reg, sin_reg;
    logic                oor_reg;
    logic [17:0]         cos_next, sin_next, cr, sr;

    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && !q_empty;

    // Numerator of the rounded fraction: pos scaled by 2^24 plus twice the size.
    assign ld_num = {1'b0, q_item.pos, 24'd0} + {23'd0, q_item.size, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]  <= ld_num[40:QB];
            dv_low_reg[0]  <= ld_num[QB-1:0];
            dv_q_reg[0]    <= '0;
            dv_den_reg[0]  <= {q_item.size, 2'b00};
            dv_side_reg[0] <= q_item.side;
        end
    end

    // One quotient bit per stage.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        logic [19:0] t;
        logic [19:0] diff;
        logic        ge;
        logic [18:0] rem_next;
        assign t        = {dv_rem_reg[s], dv_low_reg[s][QB-1]};
        assign diff     = t - {1'b0, dv_den_reg[s]};
        assign ge       = t >= {1'b0, dv_den_reg[s]};
        assign rem_next = ge ? diff[18:0] : t[18:0];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[s+1]  <= rem_next;
                dv_low_reg[s+1]  <= {dv_low_reg[s][QB-2:0], 1'b0};
                dv_q_reg[s+1]    <= {dv_q_reg[s][QB-2:0], ge};
                dv_den_reg[s+1]  <= dv_den_reg[s];
                dv_side_reg[s+1] <= dv_side_reg[s];
            end
        end
    end

    // Fraction of a turn times two pi, split in two partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_lo_reg   <= 54'(dv_q_reg[QB]) * 54'(tfg_pkg::PI_Q62[31:0]);
            mp_hi_reg   <= 54'(dv_q_reg[QB]) * 54'(tfg_pkg::PI_Q62[63:32]);
            mp_side_reg <= dv_side_reg[QB];
        end
    end

    assign ang_prod = {mp_hi_reg, 32'd0} + 86'(mp_lo_reg) + ROUND_ANGLE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]     <= signed'(tfg_pkg::GAIN_START);
            cy_reg[0]     <= '0;
            cz_reg[0]     <= signed'({1'b0, ang_prod[85:23]});
            c_side_reg[0] <= mp_side_reg;
        end
    end

    // Rotation stages with a fixed arctangent each.
    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        localparam logic signed [63:0] ATAN_STEP = signed'(tfg_pkg::atan_entry(i));
        logic signed [63:0] dx, dy;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cz_reg[i][63])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_STEP;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_STEP;
                end
                c_side_reg[i+1] <= c_side_reg[i];
            end
        end
    end

    // Round to the output format and saturate to plus or minus one.
    function automatic logic [17:0] to_output(input logic signed [63:0] v);
        logic signed [63:0] sum;
        logic signed [63:0] r;
        sum = v + (64'sd1 <<< (61 - tfg_pkg::OUTPUT_FRACTION_BITS));
        r   = sum >>> (62 - tfg_pkg::OUTPUT_FRACTION_BITS);
        if (r > 64'sd65536)
            r = 64'sd65536;
        if (r < -64'sd65536)
            r = -64'sd65536;
        return r[17:0];
    endfunction

    // Undo the octant folding and zero the outputs of an index out of range.
    always_comb
    begin
        cr = to_output(cx_reg[CS]);
        sr = to_output(cy_reg[CS]);
        cos_next = cr;
        sin_next = sr;
        if (c_side_reg[CS].fold[0])
        begin
            cos_next = sr;
            sin_next = cr;
        end
        if (c_side_reg[CS].fold[1])
        begin
            cr       = cos_next;
            cos_next = -sin_next;
            sin_next = cr;
        end
        if (c_side_reg[CS].fold[2])
            sin_next = -sin_next;
        if (c_side_reg[CS].oor)
        begin
            cos_next = '0;
            sin_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            oor_reg <= c_side_reg[CS].oor;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg  <= '0;
            mp_valid_reg  <= 1'b0;
            c_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg  <= {dv_valid_reg[QB-1:0], q_pop};
            mp_valid_reg  <= dv_valid_reg[QB];
            c_valid_reg   <= {c_valid_reg[CS-1:0], mp_valid_reg};
            out_valid_reg <= c_valid_reg[CS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, sin_reg, cos_reg};
    assign m_tuser  = oor_reg;

endmodule

### rtl/tfg_checker.sv
// Port-level checks of the twiddle generator and their binding to the top level.
module tfg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An index out of range gives zero outputs.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 40'd0)
        else $error("out-of-range item with nonzero data");

    // Cosine stays within plus or minus one.
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[17:0]) <= 18'sd65536 &&
                      $signed(m_tdata[17:0]) >= -18'sd65536))
        else $error("cosine out of range");

    // Sine stays within plus or minus one.
    a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[35:18]) <= 18'sd65536 &&
                      $signed(m_tdata[35:18]) >= -18'sd65536))
        else $error("sine out of range");

endmodule

bind twiddle_factor_generator_unit tfg_checker u_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the twiddle factor generator unit.
`timescale 1ns / 1ps

module testbench;

    // Expected result of one twiddle lookup.
    typedef struct {
        logic signed [17:0] cos_value;
        logic signed [17:0] sin_value;
        logic               out_of_range;
    } twiddle_t;

    // Computes expected twiddles and compares them with the results of the block.
    class twiddle_scoreboard;
        longint unsigned arctan_q62[tfg_pkg::CORDIC_STEPS];
        longint          gain_q62;
        longint unsigned twopi_q61;
        logic [16:0]     size;
        twiddle_t        pending[$];
        int              errors;

        // Arctangent of 1/d with 62 fraction bits by the alternating series.
        function longint unsigned arctan_inv(longint unsigned d);
            longint unsigned pw;
            longint unsigned acc;
            longint unsigned j;
            pw  = (64'd1 << 62) / d;
            acc = 0;
            j   = 0;
            while (pw != 0)
            begin
                if (j[0] == 1'b0)
                    acc = acc + pw / (2 * j + 1);
                else
                    acc = acc - pw / (2 * j + 1);
                pw = pw / d / d;
                j  = j + 1;
            end
            return acc;
        endfunction

        function longint unsigned root(longint unsigned v_in);
            longint unsigned v;
            longint unsigned r;
            longint unsigned b;
            v = v_in;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function new();
            longint unsigned gain_sq;
            gain_sq   = 64'd1 << 62;
            twopi_q61 = 16 * arctan_inv(5) - 4 * arctan_inv(239);
            for (int i = 0; i < tfg_pkg::CORDIC_STEPS; i++)
            begin
                arctan_q62[i] = (i == 0) ? (twopi_q61 >> 2) : arctan_inv(64'd1 << i);
                gain_sq = gain_sq - gain_sq / ((64'd1 << (2 * i)) + 1);
            end
            gain_q62 = longint'(root(gain_sq) << 31);
            size     = 17'd1;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == 3'd0)
                size = data[16:0];
        endfunction

        // Round to the output format, half up, and clamp to plus or minus one.
        function logic signed [17:0] to_q16(longint v);
            longint r;
            r = (v + (64'sd1 << (61 - tfg_pkg::OUTPUT_FRACTION_BITS)))
                >>> (62 - tfg_pkg::OUTPUT_FRACTION_BITS);
            if (r > 65536)
                r = 65536;
            if (r < -65536)
                r = -65536;
            return r[17:0];
        endfunction

        // Fold the angle into the first octant, rotate, then unfold.
        function void note_index(logic [15:0] k_in);
            longint unsigned k;
            longint unsigned pts;
            longint unsigned pos;
            longint unsigned full;
            longint unsigned frac;
            logic [127:0]    prod;
            logic [2:0]      fold;
            longint          x;
            longint          y;
            longint          z;
            longint          dx;
            longint          dy;
            logic signed [17:0] cv;
            logic signed [17:0] sv;
            logic signed [17:0] tmp;
            twiddle_t        t;
            k   = k_in;
            pts = size;
            if (pts > 65536)
                pts = 65536;
            if (k >= pts)
            begin
                t.cos_value    = '0;
                t.sin_value    = '0;
                t.out_of_range = 1'b1;
                pending.push_back(t);
                return;
            end
            pos  = k << 2;
            full = pts << 2;
            fold = 3'b000;
            if (pos > full - pos)
            begin
                pos     = full - pos;
                fold[2] = 1'b1;
            end
            if (pos > pts)
            begin
                pos     = pos - pts;
                fold[1] = 1'b1;
            end
            if (pos > pts - pos)
            begin
                pos     = pts - pos;
                fold[0] = 1'b1;
            end
            frac = ((pos << tfg_pkg::ANGLE_FRACTION_BITS) + 2 * pts) / full;
            prod = {64'd0, frac} * {64'd0, twopi_q61};
            prod = (prod + (128'd1 << (tfg_pkg::ANGLE_FRACTION_BITS - 2)))
                   >> (tfg_pkg::ANGLE_FRACTION_BITS - 1);
            x = gain_q62;
            y = 0;
            z = longint'(prod[63:0]);
            for (int i = 0; i < tfg_pkg::CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(arctan_q62[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(arctan_q62[i]);
                end
            end
            cv = to_q16(x);
            sv = to_q16(y);
            if (fold[0])
            begin
                tmp = cv;
                cv  = sv;
                sv  = tmp;
            end
            if (fold[1])
            begin
                tmp = cv;
                cv  = -sv;
                sv  = tmp;
            end
            if (fold[2])
                sv = -sv;
            t.cos_value    = cv;
            t.sin_value    = sv;
            t.out_of_range = 1'b0;
            pending.push_back(t);
        endfunction

        function void check_result(logic [39:0] data, logic user);
            twiddle_t t;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual data %h flag %b",
                         $time, data, user);
                errors++;
                return;
            end
            t = pending.pop_front();
            if (data[17:0] !== t.cos_value)
            begin
                $display("%0t: cos_value expected %0d actual %0d", $time,
                         t.cos_value, $signed(data[17:0]));
                errors++;
            end
            if (data[35:18] !== t.sin_value)
            begin
                $display("%0t: sin_value expected %0d actual %0d", $time,
                         t.sin_value, $signed(data[35:18]));
                errors++;
            end
            if (data[39:36] !== 4'd0)
            begin
                $display("%0t: padding expected 0 actual %h", $time, data[39:36]);
                errors++;
            end
            if (user !== t.out_of_range)
            begin
                $display("%0t: index_out_of_range expected %b actual %b", $time,
                         t.out_of_range, user);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] twiddle_index
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [17:0] cos_value, [35:18] sin_value, [39:36] zero
    logic        m_tuser;    // [0] index_out_of_range

    twiddle_scoreboard twiddles;
    bit                steady;
    int                quiet_cycles;

    twiddle_factor_generator_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        twiddles.write_reg(addr, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one index and hold it until the block takes it.
    task automatic send_index(input logic [15:0] k);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= k;
        do
            @(posedge clk);
        while (!s_tready);
        twiddles.note_index(k);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (twiddles.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Result side: random back-pressure.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            int gap;
            gap = pick_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare results and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            twiddles.check_result(m_tdata, m_tuser);
        if (rst_n && ((m_tvalid && m_tready) || (s_tvalid && s_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("twiddle_factor_generator_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] sizes[13];
        logic [16:0] n;
        int          span;
        twiddles     = new();
        steady       = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        sizes = '{32'd1, 32'd0, 32'd2, 32'd3, 32'd7, 32'd16, 32'd1000, 32'd65536,
                  32'd65537, 32'h0001_FFFF, 32'd4096, 32'd0, 32'd0};
        sizes[11] = $urandom_range(4, 65535) | ($urandom() & 32'hFFFE_0000);
        sizes[12] = $urandom_range(17, 300) | 32'hFFFE_0000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 13; p++)
        begin
            // The first phase runs on the reset value of the size.
            if (p > 0)
                write_reg(3'd0, sizes[p]);
            // A write to an unused register must leave the size alone.
            if (p == 6)
                write_reg(3'd4, $urandom());
            n      = twiddles.size;
            steady = (p == 3 || p == 9);
            span   = (n > 65536) ? 65536 : int'(n);

            // Corners: ends of the range, octant edges and the largest index.
            send_index(16'd0);
            send_index(16'hFFFF);
            if (span > 0)
            begin
                send_index(16'(span - 1));
                send_index(16'(span / 8));
                send_index(16'(span / 8 + 1));
                send_index(16'(span / 4));
                send_index(16'(span / 2));
                send_index(16'(3 * span / 4));
                send_index(16'(7 * span / 8));
                if (span <= 65535)
                    send_index(16'(span));
            end

            for (int i = 0; i < 100; i++)
            begin
                if (span > 0 && $urandom_range(0, 9) < 8)
                    send_index(16'($urandom_range(0, span - 1)));
                else
                    send_index(16'($urandom()));
                // Let the pipeline empty out once in the middle of a phase.
                if (p == 7 && i == 50)
                    drain();
            end
            drain();
        end

        if (twiddles.errors == 0)
            $display("twiddle_factor_generator_unit: match");
        else
            $display("twiddle_factor_generator_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/tfg_pkg.sv
rtl/tfg_front.sv
rtl/tfg_queue.sv
rtl/tfg_back.sv
rtl/twiddle_factor_generator_unit.sv
rtl/tfg_checker.sv
verif/testbench.sv
